### rtl/core/clbs_pkg.sv
// Package for the closest-value binary search block.
// Holds the shared types, controller commands and status, and fixed field widths.
// No dependencies.
package clbs_pkg;

   localparam int TIME_W  = 32;
   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_CHK_FIRST,
      ST_CHK_LAST,
      ST_PROBE,
      ST_CHK_MID,
      ST_CHK_BELOW,
      ST_CHK_ABOVE,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      ADDR_FIRST,
      ADDR_LAST,
      ADDR_MID_NEXT,
      ADDR_BELOW,
      ADDR_ABOVE
   } addr_sel_type;

   typedef enum logic [2:0] {
      RES_EMPTY,
      RES_FIRST,
      RES_LAST,
      RES_MID,
      RES_MID_M1,
      RES_MID_P1
   } res_sel_type;

   typedef struct packed {
      logic         mem_write;
      logic         load_query;
      addr_sel_type addr_sel;
      logic         mid_load;
      logic         vm_load;
      logic         hi_to_mid;
      logic         lo_to_mid1;
      logic         res_load;
      res_sel_type  res_sel;
      logic         out_load;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic t_le_rd;
      logic t_ge_rd;
      logic t_eq_rd;
      logic t_lt_rd;
      logic t_gt_rd;
      logic lo_lt_hi;
      logic mid_zero;
      logic above_in_range;
      logic pick_upper_below;
      logic pick_upper_above;
   } status_type;

endpackage

### rtl/core/clbs_ctrl.sv
// Controller state machine of the closest-value search.
// Sequences reads, probes and result hand-off; depends on clbs_pkg.
module clbs_ctrl
   import clbs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_operation,
   input  logic       rsp_free,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.addr_sel = ADDR_FIRST;
      cmd.res_sel  = RES_EMPTY;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == OP_QUERY) begin
                  cmd.load_query = 1'b1;
                  state_in       = ST_START;
               end else begin
                  cmd.mem_write = 1'b1;
               end
            end
         end
         ST_START: begin
            if (status.n_zero) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_EMPTY;
               state_in     = ST_DONE;
            end else begin
               cmd.addr_sel = ADDR_FIRST;
               state_in     = ST_CHK_FIRST;
            end
         end
         ST_CHK_FIRST: begin
            if (status.t_le_rd) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_FIRST;
               state_in     = ST_DONE;
            end else begin
               cmd.addr_sel = ADDR_LAST;
               state_in     = ST_CHK_LAST;
            end
         end
         ST_CHK_LAST: begin
            if (status.t_ge_rd) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_LAST;
               state_in     = ST_DONE;
            end else begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (status.lo_lt_hi) begin
               cmd.mid_load = 1'b1;
               cmd.addr_sel = ADDR_MID_NEXT;
               state_in     = ST_CHK_MID;
            end else begin
               // search ran dry (unsorted store): last midpoint stands
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_MID;
               state_in     = ST_DONE;
            end
         end
         ST_CHK_MID: begin
            cmd.vm_load = 1'b1;
            if (status.t_eq_rd) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_MID;
               state_in     = ST_DONE;
            end else if (status.t_lt_rd) begin
               if (!status.mid_zero) begin
                  cmd.addr_sel = ADDR_BELOW;
                  state_in     = ST_CHK_BELOW;
               end else begin
                  cmd.hi_to_mid = 1'b1;
                  state_in      = ST_PROBE;
               end
            end else begin
               if (status.above_in_range) begin
                  cmd.addr_sel = ADDR_ABOVE;
                  state_in     = ST_CHK_ABOVE;
               end else begin
                  cmd.lo_to_mid1 = 1'b1;
                  state_in       = ST_PROBE;
               end
            end
         end
         ST_CHK_BELOW: begin
            if (status.t_gt_rd) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = status.pick_upper_below ? RES_MID : RES_MID_M1;
               state_in     = ST_DONE;
            end else begin
               cmd.hi_to_mid = 1'b1;
               state_in      = ST_PROBE;
            end
         end
         ST_CHK_ABOVE: begin
            if (status.t_lt_rd) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = status.pick_upper_above ? RES_MID_P1 : RES_MID;
               state_in     = ST_DONE;
            end else begin
               cmd.lo_to_mid1 = 1'b1;
               state_in       = ST_PROBE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/core/clbs_datapath.sv
// Datapath of the closest-value search: timestamp store, search bounds,
// comparators and result register. Depends on clbs_pkg.
module clbs_datapath
   import clbs_pkg::*;
#(
   parameter int MAX_ENTRIES = 1024
)
(
   input  logic                       clock,
   input  logic [INDEX_W-1:0]         req_write_index,
   input  logic signed [TIME_W-1:0]   req_write_time,
   input  logic signed [TIME_W-1:0]   req_query_time,
   input  logic [COUNT_W-1:0]         entry_count,
   input  cmd_type                    cmd,
   output status_type                 status,
   output logic                       res_found,
   output logic [INDEX_W-1:0]         res_index
);

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = AW + 1;

   logic signed [TIME_W-1:0] mem [MAX_ENTRIES];

   logic signed [TIME_W-1:0] target_ff;
   logic signed [TIME_W-1:0] vm_ff;
   logic signed [TIME_W-1:0] rd_ff;
   logic [CW-1:0]            n_ff;
   logic [CW-1:0]            lo_ff;
   logic [CW-1:0]            hi_ff;
   logic [AW-1:0]            mid_ff;
   logic                     res_found_ff;
   logic [AW-1:0]            res_index_ff;

   logic [CW-1:0]            n_in;
   logic [CW:0]              bound_sum;
   logic [AW-1:0]            mid_next;
   logic [CW-1:0]            mid_p1;
   logic [AW-1:0]            rd_addr;
   logic                     wr_in_range;
   logic [AW-1:0]            res_index_in;
   logic signed [TIME_W+1:0] d_t_rd;
   logic signed [TIME_W+1:0] d_vm_t;
   logic signed [TIME_W+1:0] d_t_vm;
   logic signed [TIME_W+1:0] d_rd_t;

   // clamp the programmed count to the store depth
   always_comb begin
      if (32'(entry_count) > 32'(MAX_ENTRIES)) begin
         n_in = CW'(MAX_ENTRIES);
      end else begin
         n_in = CW'(entry_count);
      end
   end

   assign bound_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_next    = bound_sum[AW:1];
   assign mid_p1      = CW'(mid_ff) + CW'(1);
   assign wr_in_range = (32'(req_write_index) < 32'(MAX_ENTRIES));

   always_comb begin
      unique case (cmd.addr_sel)
         ADDR_FIRST:    rd_addr = '0;
         ADDR_LAST:     rd_addr = AW'(n_ff - CW'(1));
         ADDR_MID_NEXT: rd_addr = mid_next;
         ADDR_BELOW:    rd_addr = mid_ff - AW'(1);
         ADDR_ABOVE:    rd_addr = AW'(mid_p1);
         default:       rd_addr = '0;
      endcase
   end

   // store with separate write and read addresses, registered read
   always_ff @(posedge clock) begin
      if (cmd.mem_write && wr_in_range) begin
         mem[AW'(req_write_index)] <= req_write_time;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         target_ff <= req_query_time;
         n_ff      <= n_in;
         lo_ff     <= '0;
         hi_ff     <= n_in;
         mid_ff    <= '0;
      end else begin
         if (cmd.mid_load) begin
            mid_ff <= mid_next;
         end
         if (cmd.hi_to_mid) begin
            hi_ff <= CW'(mid_ff);
         end
         if (cmd.lo_to_mid1) begin
            lo_ff <= mid_p1;
         end
      end
      if (cmd.vm_load) begin
         vm_ff <= rd_ff;
      end
   end

   always_comb begin
      unique case (cmd.res_sel)
         RES_EMPTY:  res_index_in = '0;
         RES_FIRST:  res_index_in = '0;
         RES_LAST:   res_index_in = AW'(n_ff - CW'(1));
         RES_MID:    res_index_in = mid_ff;
         RES_MID_M1: res_index_in = mid_ff - AW'(1);
         RES_MID_P1: res_index_in = AW'(mid_p1);
         default:    res_index_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         res_found_ff <= (cmd.res_sel != RES_EMPTY);
         res_index_ff <= res_index_in;
      end
   end

   assign res_found = res_found_ff;
   assign res_index = INDEX_W'(res_index_ff);

   // 34-bit differences never overflow
   assign d_t_rd = (TIME_W+2)'(target_ff) - (TIME_W+2)'(rd_ff);
   assign d_vm_t = (TIME_W+2)'(vm_ff) - (TIME_W+2)'(target_ff);
   assign d_t_vm = (TIME_W+2)'(target_ff) - (TIME_W+2)'(vm_ff);
   assign d_rd_t = (TIME_W+2)'(rd_ff) - (TIME_W+2)'(target_ff);

   always_comb begin
      status.n_zero           = (n_ff == '0);
      status.t_le_rd          = (target_ff <= rd_ff);
      status.t_ge_rd          = (target_ff >= rd_ff);
      status.t_eq_rd          = (target_ff == rd_ff);
      status.t_lt_rd          = (target_ff < rd_ff);
      status.t_gt_rd          = (target_ff > rd_ff);
      status.lo_lt_hi         = (lo_ff < hi_ff);
      status.mid_zero         = (mid_ff == '0);
      status.above_in_range   = (mid_p1 < n_ff);
      status.pick_upper_below = (d_t_rd >= d_vm_t);
      status.pick_upper_above = (d_t_vm >= d_rd_t);
   end

endmodule

### rtl/core/closest_value_binary_search.sv
// Top level of the closest-value binary search over a sorted timestamp store.
// Joins clbs_ctrl and clbs_datapath; holds the count register and result register.
// Depends on clbs_pkg.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------
//   req     | in        | req_valid/req_stall  | operation, write_index, write/query time
//   rsp     | out       | rsp_valid/rsp_stall  | found, closest_index
//   csr     | in        | csr_wr_en            | entry_count (csr_wr_data)
//
// A write item is stored at the edge of its transfer.
// A query steps from transfer to result register through start, first and last entry, then per
// probe a midpoint read, a compare that issues the neighbour read and a neighbour compare,
// over p probes (at most about log2(count) + 1).
// Early exits skip steps; a result still held in the output register adds its wait.
// Reset (synchronous, active high) clears the controller, the result valid and the
// count; store contents are undefined until written. The next item is taken while a
// result still waits on rsp_stall; a later query waits only to hand its result over.
module closest_value_binary_search
   import clbs_pkg::*;
#(
   parameter int MAX_ENTRIES = 1024
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_operation,
   input  logic [INDEX_W-1:0]       req_write_index,
   input  logic signed [TIME_W-1:0] req_write_time,
   input  logic signed [TIME_W-1:0] req_query_time,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_found,
   output logic [INDEX_W-1:0]       rsp_closest_index,
   input  logic                     csr_wr_en,
   input  logic [COUNT_W-1:0]       csr_wr_data
);

   logic [COUNT_W-1:0] entry_count_ff;
   logic               rsp_valid_ff;
   logic               rsp_found_ff;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic               rsp_free;
   cmd_type            cmd;
   status_type         status;
   logic               res_found;
   logic [INDEX_W-1:0] res_index;

   // configuration register: number of valid entries
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_wr_en) begin
         entry_count_ff <= csr_wr_data;
      end
   end

   clbs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .rsp_free      (rsp_free),
      .status        (status),
      .cmd           (cmd)
   );

   clbs_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock           (clock),
      .req_write_index (req_write_index),
      .req_write_time  (req_write_time),
      .req_query_time  (req_query_time),
      .entry_count     (entry_count_ff),
      .cmd             (cmd),
      .status          (status),
      .res_found       (res_found),
      .res_index       (res_index)
   );

   // result register: free when empty or being taken this cycle
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_found_ff <= res_found;
         rsp_index_ff <= res_index;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_closest_index = rsp_index_ff;

endmodule

### verif/closest_search_tb_pkg.sv
// Scoreboard for the closest-value binary search testbench: a copy of the timestamp store,
// the entry count, a predictor of the closest-entry search and the queue of expected results.
// Depends on clbs_pkg.
package closest_search_tb_pkg;
   import clbs_pkg::*;

   localparam int STORE_DEPTH = 1024;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] closest_index;
   } search_result_type;

   class closest_index_board_type;
      logic signed [TIME_W-1:0] entry_times [STORE_DEPTH];
      logic [COUNT_W-1:0]       entry_count;
      search_result_type        pending_closest [$];
      int                       errors;

      function new();
         foreach (entry_times[i]) entry_times[i] = '0;
         entry_count = '0;
         errors      = 0;
      endfunction

      function void set_entry_count(logic [COUNT_W-1:0] value);
         entry_count = value;
      endfunction

      // counts above the store depth are clamped
      function int unsigned active_entries();
         return (entry_count > STORE_DEPTH) ? STORE_DEPTH : int'(entry_count);
      endfunction

      function longint time_at(int unsigned k);
         if (k >= STORE_DEPTH) return 0;
         return longint'(entry_times[k]);
      endfunction

      function logic [INDEX_W-1:0] closest_of(int unsigned n, longint t);
         int unsigned lo;
         int unsigned hi;
         int unsigned mid;
         longint      vm;
         longint      vb;
         longint      va;
         lo  = 0;
         hi  = n;
         mid = 0;
         if (t <= time_at(0)) return '0;
         if (t >= time_at(n - 1)) return INDEX_W'(n - 1);
         while (lo < hi) begin
            mid = (lo + hi) >> 1;
            vm  = time_at(mid);
            if (vm == t) return INDEX_W'(mid);
            if (t < vm) begin
               if (mid > 0) begin
                  vb = time_at(mid - 1);
                  if (t > vb) return (t - vb >= vm - t) ? INDEX_W'(mid) : INDEX_W'(mid - 1);
               end
               hi = mid;
            end else begin
               if (mid + 1 < n) begin
                  va = time_at(mid + 1);
                  if (t < va) return (t - vm >= va - t) ? INDEX_W'(mid + 1) : INDEX_W'(mid);
               end
               lo = mid + 1;
            end
         end
         return INDEX_W'(mid);
      endfunction

      function void note_request(logic op, logic [INDEX_W-1:0] idx,
                                 logic signed [TIME_W-1:0] wtime,
                                 logic signed [TIME_W-1:0] qtime);
         search_result_type res;
         int unsigned       n;
         if (op == OP_WRITE) begin
            entry_times[idx] = wtime;
         end else begin
            n = active_entries();
            if (n == 0) begin
               res.found         = 1'b0;
               res.closest_index = '0;
            end else begin
               res.found         = 1'b1;
               res.closest_index = closest_of(n, longint'(qtime));
            end
            pending_closest.push_back(res);
         end
      endfunction

      function void check_result(logic found, logic [INDEX_W-1:0] index);
         search_result_type want;
         if (pending_closest.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual found=%0b index=%0d",
                     $time, found, index);
            return;
         end
         want = pending_closest.pop_front();
         if (found !== want.found) begin
            errors++;
            $display("%0t: found mismatch: expected %0b, actual %0b", $time, want.found, found);
         end
         if (index !== want.closest_index) begin
            errors++;
            $display("%0t: closest_index mismatch: expected %0d, actual %0d",
                     $time, want.closest_index, index);
         end
      endfunction

      function int pending();
         return pending_closest.size();
      endfunction
   endclass

endpackage

### verif/closest_value_binary_search_tb.sv
// Top-level testbench of closest_value_binary_search: directed and random write and query
// transfers, idling on both channels, results checked against the scoreboard's predictor.
// Depends on clbs_pkg, closest_search_tb_pkg and the block's RTL.
module closest_value_binary_search_tb
   import clbs_pkg::*;
   import closest_search_tb_pkg::*;
();

   // covers any search still in flight
   localparam int SETTLE_CYCLES = 64;
   // random transfers after the directed part
   localparam int RANDOM_ITEMS  = 700;

   localparam longint TIME_MIN = -64'sd2147483648;
   localparam longint TIME_MAX = 64'sd2147483647;
   localparam logic signed [TIME_W-1:0] T_MIN = 32'sh8000_0000;
   localparam logic signed [TIME_W-1:0] T_MAX = 32'sh7fff_ffff;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic                     req_operation;
   logic [INDEX_W-1:0]       req_write_index;
   logic signed [TIME_W-1:0] req_write_time;
   logic signed [TIME_W-1:0] req_query_time;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_found;
   logic [INDEX_W-1:0]       rsp_closest_index;
   logic                     csr_wr_en;
   logic [COUNT_W-1:0]       csr_wr_data;

   closest_index_board_type closest_board;

   // idling percentages of the two channels, changed by phase
   int send_idle_pct;
   int rsp_idle_pct;

   // which store entries hold a written value; queries only cover the written prefix
   bit written [STORE_DEPTH];
   int written_prefix;
   int items_sent;

   closest_value_binary_search dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_write_index   (req_write_index),
      .req_write_time    (req_write_time),
      .req_query_time    (req_query_time),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_closest_index (rsp_closest_index),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= (int'($urandom_range(99)) < rsp_idle_pct);
   end

   // Outputs are sampled at the falling edge: valid and stall are settled there and
   // decide the transfer at the next rising edge.
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         closest_board.check_result(rsp_found, rsp_closest_index);
   end

   function automatic logic signed [TIME_W-1:0] sat_time(longint v);
      if (v < TIME_MIN) return T_MIN;
      if (v > TIME_MAX) return T_MAX;
      return TIME_W'(v);
   endfunction

   // One transfer on the request channel. Entered and left at a rising edge.
   task automatic send_item(logic op, logic [INDEX_W-1:0] idx,
                            logic signed [TIME_W-1:0] wtime,
                            logic signed [TIME_W-1:0] qtime);
      bit taken;
      while (int'($urandom_range(99)) < send_idle_pct) begin
         // idle cycle; the payload is free to wander while valid is low
         req_valid       <= 1'b0;
         req_operation   <= 1'($urandom);
         req_write_index <= INDEX_W'($urandom);
         req_write_time  <= $urandom;
         req_query_time  <= $urandom;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_write_index <= idx;
      req_write_time  <= wtime;
      req_query_time  <= qtime;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         if (taken) closest_board.note_request(op, idx, wtime, qtime);
         @(posedge clock);
      end
      if (op == OP_WRITE) begin
         written[idx] = 1'b1;
         while (written_prefix < STORE_DEPTH && written[written_prefix])
            written_prefix++;
      end
      items_sent++;
   endtask

   task automatic write_entry(logic [INDEX_W-1:0] idx, logic signed [TIME_W-1:0] t);
      send_item(OP_WRITE, idx, t, $urandom);
   endtask

   task automatic query_at(logic signed [TIME_W-1:0] t);
      send_item(OP_QUERY, INDEX_W'($urandom), $urandom, t);
   endtask

   // Sender holds off until every expected result has come, then lets the block settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (closest_board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Count register written only with the block idle.
   task automatic program_count(logic [COUNT_W-1:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      closest_board.set_entry_count(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= COUNT_W'($urandom);
   endtask

   // Ascending list at positions 0..n-1, steps drawn up to step_max (0 gives duplicates).
   // pin_ends puts the most negative and most positive times at the two ends.
   task automatic load_sorted(int n, longint step_max, bit pin_ends);
      longint span;
      longint base;
      longint v;
      span = step_max * (n - 1);
      if (span >= 64'sd4294967295)
         base = TIME_MIN;
      else
         base = TIME_MIN + (longint'($urandom) % (64'sd4294967296 - span));
      v = base;
      for (int i = 0; i < n; i++) begin
         if (i > 0) v += longint'($urandom) % (step_max + 1);
         if (pin_ends && n > 1 && i == 0)
            write_entry(INDEX_W'(i), T_MIN);
         else if (pin_ends && n > 1 && i == n - 1)
            write_entry(INDEX_W'(i), T_MAX);
         else
            write_entry(INDEX_W'(i), sat_time(v));
      end
   endtask

   // Queries aimed at the current list: exact hits, one off, midpoints (ties when the gap
   // is even), beyond either end, the extremes and plain noise. A few stray writes inside
   // the written part make the list unsorted, and now and then the sender waits for all
   // results.
   task automatic run_queries(int nq);
      int unsigned              n;
      int unsigned              k;
      longint                   a;
      longint                   b;
      logic signed [TIME_W-1:0] qt;
      for (int q = 0; q < nq; q++) begin
         n = closest_board.active_entries();
         if ($urandom_range(99) < 8 && written_prefix > 0) begin
            write_entry(INDEX_W'($urandom_range(written_prefix - 1)), $urandom);
         end else if ($urandom_range(99) < 3) begin
            drain_results();
         end else begin
            qt = $urandom;
            if (n != 0) begin
               k = $urandom_range(n - 1);
               a = longint'(closest_board.entry_times[k]);
               b = (k + 1 < n) ? longint'(closest_board.entry_times[k + 1]) : a;
               case ($urandom_range(9))
                  0: qt = sat_time(a);
                  1: qt = sat_time(a + 1);
                  2: qt = sat_time(a - 1);
                  3: qt = sat_time((a + b) >>> 1);
                  4: qt = sat_time(closest_board.time_at(0) - $urandom_range(1000, 1));
                  5: qt = sat_time(closest_board.time_at(n - 1) + $urandom_range(1000, 1));
                  6: qt = T_MIN;
                  7: qt = T_MAX;
                  default: qt = $urandom;
               endcase
            end
            query_at(qt);
         end
      end
   endtask

   initial begin
      longint step;
      int     n_load;
      int     progress;
      int     start_items;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_operation   = OP_WRITE;
      req_write_index = '0;
      req_write_time  = '0;
      req_query_time  = '0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      written_prefix  = 0;
      items_sent      = 0;
      send_idle_pct   = 32;
      rsp_idle_pct    = 47;
      closest_board   = new();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // ---- directed ----
      // empty list: not found
      program_count('0);
      query_at('0);
      query_at(T_MIN);

      // four evenly spaced entries: ties go up, exact hit, both ends and beyond
      write_entry(10'd0, 32'sd0);
      write_entry(10'd1, 32'sd10);
      write_entry(10'd2, 32'sd20);
      write_entry(10'd3, 32'sd30);
      program_count(11'd4);
      query_at(32'sd5);
      query_at(32'sd15);
      query_at(32'sd25);
      query_at(32'sd20);
      query_at(32'sd0);
      query_at(T_MIN);
      query_at(32'sd30);
      query_at(T_MAX);
      query_at(32'sd12);

      // single entry
      program_count(11'd1);
      query_at(32'sd7);

      // extreme timestamps stored at the ends
      write_entry(10'd0, T_MIN);
      write_entry(10'd3, T_MAX);
      program_count(11'd4);
      query_at(T_MIN);
      query_at(T_MAX);
      query_at(32'sh4000_0000);

      // unsorted store: the search still ends on some index
      write_entry(10'd1, T_MAX);
      query_at(32'sd15);

      // ---- random phases ----
      // first third: sender idles 32%, receiver 47%; then swapped; then no idling
      start_items = items_sent;
      progress    = 0;
      while (progress < RANDOM_ITEMS) begin
         if (progress < RANDOM_ITEMS / 3) begin
            send_idle_pct = 32;
            rsp_idle_pct  = 47;
         end else if (progress < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 47;
            rsp_idle_pct  = 32;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end

         // mostly short lists, now and then a longer one
         n_load = ($urandom_range(9) == 0) ? $urandom_range(300, 41) : $urandom_range(40, 1);
         case ($urandom_range(3))
            0: step = 2;
            1: step = 1000;
            2: step = 64'sd65536;
            default: step = 64'sd4294967295 / n_load;
         endcase
         load_sorted(n_load, step, ($urandom_range(7) == 0));

         // counts stay within the written part of the store
         case ($urandom_range(9))
            0: program_count('0);
            1: program_count(COUNT_W'($urandom_range(written_prefix)));
            2: program_count(COUNT_W'(written_prefix));
            default: program_count(COUNT_W'(n_load));
         endcase
         run_queries($urandom_range(30, 10));
         progress = items_sent - start_items;
      end

      // ---- end of run ----
      drain_results();
      if (closest_board.errors == 0)
         $display("closest_value_binary_search_tb: PASS");
      else
         $display("closest_value_binary_search_tb: FAIL");
      $finish;
   end

   // run limit, well beyond the slowest correct run
   initial begin
      #30_000_000;
      $display("closest_value_binary_search_tb: FAIL");
      $finish;
   end

endmodule
